@@ sv/drts_pkg.sv @@
`default_nettype none

package drts_pkg;

	// Command codes of an input item
	localparam logic [2:0] CMD_LOAD     = 3'd0;
	localparam logic [2:0] CMD_START    = 3'd1;
	localparam logic [2:0] CMD_TRANS    = 3'd2;
	localparam logic [2:0] CMD_READ_RES = 3'd3;
	localparam logic [2:0] CMD_READ_CNT = 3'd4;
	localparam logic [2:0] CMD_CLEAR    = 3'd5;

	// Status codes of a result item
	localparam logic [1:0] STS_DONE    = 2'd0;
	localparam logic [1:0] STS_IGNORED = 2'd1;
	localparam logic [1:0] STS_RANGE   = 2'd2;
	localparam logic [1:0] STS_DROPPED = 2'd3;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] freq;
		logic [63:0] now_time;
		logic [3:0]  from_index;
		logic [3:0]  to_index;
	} item_t;

	typedef struct packed {
		logic [63:0] value;
		logic [31:0] total_transitions;
		logic [3:0]  current_index;
		logic        current_valid;
		logic [4:0]  entry_count;
		logic [1:0]  status;
	} result_t;

	// Shared adder operations
	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_INC
	} alu_op_t;

	typedef struct packed {
		alu_op_t     op;
		logic [63:0] a;
		logic [63:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [63:0] sum;
		logic        eq;
	} alu_rsp_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_DIFF,
		ST_ACCUM,
		ST_READ,
		ST_RES_OUT,
		ST_CNT_RD,
		ST_CNT_OUT,
		ST_CNT_INC,
		ST_TOTAL,
		ST_WIPE,
		ST_FINISH
	} drts_state_t;

endpackage

`default_nettype wire

@@ sv/drts_alu.sv @@
`default_nettype none

module drts_alu (
	input  wire drts_pkg::alu_req_t req,
	output drts_pkg::alu_rsp_t rsp
);
	import drts_pkg::*;

	logic [63:0] operand_b;
	logic        carry_in;

	// Select second operand and carry for add, subtract, increment
	always_comb begin
		case (req.op)
		ALU_ADD: begin
			operand_b = req.b;
			carry_in  = 1'b0;
		end
		ALU_SUB: begin
			operand_b = ~req.b;
			carry_in  = 1'b1;
		end
		ALU_INC: begin
			operand_b = '0;
			carry_in  = 1'b1;
		end
		default: begin
			operand_b = req.b;
			carry_in  = 1'b0;
		end
		endcase
	end

	assign rsp.sum = req.a + operand_b + 64'(carry_in);
	assign rsp.eq  = (req.a == req.b);

endmodule

`default_nettype wire

@@ sv/dvfs_residency_transition_stats.sv @@
`default_nettype none

// Operating-point residency and transition statistics. Frequencies are loaded
// into a table (duplicates dropped); start, transition, read and clear items
// then track time spent per table index and a from-to transition matrix. One
// item is handled at a time under a small sequencer driving one shared 64-bit
// adder/comparator and memories with one read and one write port. Load, start
// and transition items look up the table one entry per cycle; a clear runs a
// sweep that zeroes the count matrix and residency table one cell per cycle,
// and after reset the same sweep runs with item_stall high. A finished result
// waits in an output register, so the next item may be taken while it is
// pending.
module dvfs_residency_transition_stats #(
	parameter int MAX_STATES = 16,
	parameter int COUNT_BITS = 32
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_stall,
	input  wire drts_pkg::item_t item,
	output logic                result_valid,
	input  wire                 result_stall,
	output drts_pkg::result_t   result
);
	import drts_pkg::*;

	localparam int IDX_W = $clog2(MAX_STATES);
	localparam int ENT_W = $clog2(MAX_STATES + 1);
	localparam int CELLS = MAX_STATES * MAX_STATES;
	localparam int AW    = $clog2(CELLS);

	drts_state_t state_q, state_d;

	// Control state
	logic [ENT_W-1:0]      entry_total_q;
	logic [COUNT_BITS-1:0] total_q;
	logic [63:0]           last_q;
	logic [IDX_W-1:0]      cur_q;
	logic                  known_q;
	logic [AW-1:0]         sweep_q;
	logic [ENT_W-1:0]      scan_q;
	logic                  pend_s1;
	logic                  result_valid_q;

	// Item payload and working registers
	item_t                 item_q;
	logic [63:0]           value_q;
	logic [1:0]            status_q;
	logic [63:0]           diff_q;
	logic [IDX_W-1:0]      new_idx_q;
	logic [IDX_W-1:0]      pend_idx_s1;
	result_t               result_q;

	// Memories
	logic [31:0]           freq_mem [MAX_STATES];
	logic [63:0]           res_mem [MAX_STATES];
	logic [COUNT_BITS-1:0] cnt_mem [CELLS];
	logic [31:0]           freq_rd_q;
	logic [63:0]           res_rd_q;
	logic [COUNT_BITS-1:0] cnt_rd_q;

	logic                  freq_we;
	logic [IDX_W-1:0]      freq_waddr;
	logic [IDX_W-1:0]      freq_raddr;
	logic                  res_we;
	logic [IDX_W-1:0]      res_waddr;
	logic [63:0]           res_wdata;
	logic [IDX_W-1:0]      res_raddr;
	logic                  cnt_we;
	logic [AW-1:0]         cnt_waddr;
	logic [COUNT_BITS-1:0] cnt_wdata;
	logic [AW-1:0]         cnt_addr;

	alu_req_t              alu_req;
	alu_rsp_t              alu_rsp;

	logic                  accept;
	logic                  out_free;
	logic                  sweep_done;
	logic                  scan_issue;
	logic                  scan_hit;
	logic                  scan_miss;
	logic                  table_full;
	logic                  res_ok;
	logic                  cnt_ok;

	drts_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign out_free   = !result_valid_q || !result_stall;
	assign sweep_done = (sweep_q == AW'(CELLS - 1));

	// Table lookup: one read issued and one compare per cycle
	assign scan_issue = (scan_q < entry_total_q);
	assign scan_hit   = pend_s1 && alu_rsp.eq;
	assign scan_miss  = !pend_s1 && !scan_issue;

	assign table_full = (32'(entry_total_q) >= MAX_STATES);
	assign res_ok     = (32'(item_q.from_index) < 32'(entry_total_q));
	assign cnt_ok     = res_ok && (32'(item_q.to_index) < 32'(entry_total_q));

	// Matrix cell: current to new state for a transition, else the queried pair
	always_comb begin
		if (item_q.cmd == CMD_TRANS) begin
			cnt_addr = AW'(32'(cur_q) * MAX_STATES + 32'(new_idx_q));
		end else begin
			cnt_addr = AW'(32'(item_q.from_index) * MAX_STATES + 32'(item_q.to_index));
		end
	end

	// Drive the shared unit from the current step
	always_comb begin
		alu_req.op = ALU_ADD;
		alu_req.a  = '0;
		alu_req.b  = '0;
		case (state_q)
		ST_SCAN: begin
			alu_req.a = 64'(freq_rd_q);
			alu_req.b = 64'(item_q.freq);
		end
		ST_DIFF: begin
			alu_req.op = ALU_SUB;
			alu_req.a  = item_q.now_time;
			alu_req.b  = last_q;
		end
		ST_ACCUM: begin
			alu_req.a = res_rd_q;
			alu_req.b = diff_q;
		end
		ST_CNT_INC: begin
			alu_req.op = ALU_INC;
			alu_req.a  = 64'(cnt_rd_q);
		end
		ST_TOTAL: begin
			alu_req.op = ALU_INC;
			alu_req.a  = 64'(total_q);
		end
		default: begin
			alu_req.op = ALU_ADD;
		end
		endcase
	end

	// Memory port control
	always_comb begin
		freq_raddr = IDX_W'(scan_q);
		freq_waddr = IDX_W'(entry_total_q);
		freq_we    = (state_q == ST_SCAN) && scan_miss && (item_q.cmd == CMD_LOAD);
		res_raddr  = (state_q == ST_READ) ? IDX_W'(item_q.from_index) : cur_q;
		res_we     = 1'b0;
		res_waddr  = cur_q;
		res_wdata  = alu_rsp.sum;
		cnt_we     = 1'b0;
		cnt_waddr  = cnt_addr;
		cnt_wdata  = COUNT_BITS'(alu_rsp.sum);
		case (state_q)
		ST_INIT, ST_WIPE: begin
			cnt_we    = 1'b1;
			cnt_waddr = sweep_q;
			cnt_wdata = '0;
			res_we    = (32'(sweep_q) < MAX_STATES);
			res_waddr = IDX_W'(sweep_q);
			res_wdata = '0;
		end
		ST_ACCUM: begin
			res_we = 1'b1;
		end
		ST_CNT_INC: begin
			cnt_we = 1'b1;
		end
		default: begin
			cnt_we = 1'b0;
		end
		endcase
	end

	// Hold the memories; read data is registered
	always_ff @(posedge clk) begin
		freq_rd_q <= freq_mem[freq_raddr];
		if (freq_we) begin
			freq_mem[freq_waddr] <= item_q.freq;
		end
	end

	always_ff @(posedge clk) begin
		res_rd_q <= res_mem[res_raddr];
		if (res_we) begin
			res_mem[res_waddr] <= res_wdata;
		end
	end

	always_ff @(posedge clk) begin
		cnt_rd_q <= cnt_mem[cnt_addr];
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
		ST_INIT: begin
			if (sweep_done) state_d = ST_IDLE;
		end
		ST_IDLE: begin
			if (accept) state_d = ST_DECODE;
		end
		ST_DECODE: begin
			case (item_q.cmd)
			CMD_LOAD:     state_d = table_full ? ST_FINISH : ST_SCAN;
			CMD_START:    state_d = ST_SCAN;
			CMD_TRANS:    state_d = known_q ? ST_SCAN : ST_FINISH;
			CMD_READ_RES: state_d = known_q ? ST_DIFF : ST_READ;
			CMD_READ_CNT: state_d = cnt_ok ? ST_CNT_RD : ST_FINISH;
			CMD_CLEAR:    state_d = ST_WIPE;
			default:      state_d = ST_FINISH;
			endcase
		end
		ST_SCAN: begin
			if (scan_hit) begin
				if (item_q.cmd == CMD_TRANS && pend_idx_s1 != cur_q) begin
					state_d = ST_DIFF;
				end else begin
					state_d = ST_FINISH;
				end
			end else if (scan_miss) begin
				state_d = ST_FINISH;
			end
		end
		ST_DIFF:    state_d = ST_ACCUM;
		ST_ACCUM:   state_d = (item_q.cmd == CMD_TRANS) ? ST_CNT_RD : ST_READ;
		ST_READ:    state_d = res_ok ? ST_RES_OUT : ST_FINISH;
		ST_RES_OUT: state_d = ST_FINISH;
		ST_CNT_RD:  state_d = (item_q.cmd == CMD_TRANS) ? ST_CNT_INC : ST_CNT_OUT;
		ST_CNT_OUT: state_d = ST_FINISH;
		ST_CNT_INC: state_d = ST_TOTAL;
		ST_TOTAL:   state_d = ST_FINISH;
		ST_WIPE: begin
			if (sweep_done) state_d = ST_FINISH;
		end
		ST_FINISH: begin
			if (out_free) state_d = ST_IDLE;
		end
		default:    state_d = ST_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Update control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_total_q <= '0;
			total_q       <= '0;
			last_q        <= '0;
			cur_q         <= '0;
			known_q       <= 1'b0;
			sweep_q       <= '0;
			scan_q        <= '0;
			pend_s1       <= 1'b0;
		end else begin
			case (state_q)
			ST_INIT, ST_WIPE: begin
				sweep_q <= sweep_done ? '0 : sweep_q + AW'(1);
			end
			ST_IDLE: begin
				scan_q  <= '0;
				pend_s1 <= 1'b0;
			end
			ST_DECODE: begin
				if (item_q.cmd == CMD_START) begin
					last_q <= item_q.now_time;
				end
				if (item_q.cmd == CMD_CLEAR) begin
					last_q  <= item_q.now_time;
					total_q <= '0;
					sweep_q <= '0;
				end
			end
			ST_SCAN: begin
				scan_q  <= scan_q + ENT_W'(scan_issue);
				pend_s1 <= scan_issue && !scan_hit;
				if (item_q.cmd == CMD_LOAD && scan_miss) begin
					entry_total_q <= entry_total_q + ENT_W'(1);
				end
				if (item_q.cmd == CMD_START && scan_hit) begin
					cur_q   <= pend_idx_s1;
					known_q <= 1'b1;
				end
				if (item_q.cmd == CMD_START && scan_miss) begin
					cur_q   <= '0;
					known_q <= 1'b0;
				end
			end
			ST_ACCUM: begin
				last_q <= item_q.now_time;
			end
			ST_TOTAL: begin
				total_q <= COUNT_BITS'(alu_rsp.sum);
				cur_q   <= new_idx_q;
			end
			default: begin
				pend_s1 <= 1'b0;
			end
			endcase
		end
	end

	// Hold the item and per-item working values
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		pend_idx_s1 <= IDX_W'(scan_q);
		case (state_q)
		ST_DECODE: begin
			value_q <= '0;
			if (item_q.cmd == CMD_LOAD && table_full) status_q <= STS_DROPPED;
			else if (item_q.cmd == CMD_TRANS && !known_q) status_q <= STS_IGNORED;
			else if (item_q.cmd == CMD_READ_CNT && !cnt_ok) status_q <= STS_RANGE;
			else status_q <= STS_DONE;
		end
		ST_SCAN: begin
			new_idx_q <= pend_idx_s1;
			if (item_q.cmd == CMD_LOAD && scan_hit) status_q <= STS_DROPPED;
			if (item_q.cmd == CMD_TRANS && (scan_miss || (scan_hit && pend_idx_s1 == cur_q))) begin
				status_q <= STS_IGNORED;
			end
		end
		ST_DIFF: begin
			diff_q <= alu_rsp.sum;
		end
		ST_READ: begin
			if (!res_ok) status_q <= STS_RANGE;
		end
		ST_RES_OUT: begin
			value_q <= res_rd_q;
		end
		ST_CNT_OUT: begin
			value_q <= 64'(cnt_rd_q);
		end
		default: begin
			diff_q <= diff_q;
		end
		endcase
	end

	// Output register: load on finish, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			result_q.value             <= value_q;
			result_q.total_transitions <= 32'(total_q);
			result_q.current_index     <= 4'(cur_q);
			result_q.current_valid     <= known_q;
			result_q.entry_count       <= 5'(entry_total_q);
			result_q.status            <= status_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A result appears only out of the finishing step
	property p_result_from_finish;
		@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> ($past(state_q) == ST_FINISH);
	endproperty
	a_result_from_finish: assert property (p_result_from_finish)
		else $error("result raised outside finish step");

	// An unknown current state always reads as index zero
	property p_unknown_zero;
		@(posedge clk) disable iff (!arst_n)
		!known_q |-> (cur_q == '0);
	endproperty
	a_unknown_zero: assert property (p_unknown_zero)
		else $error("current index nonzero while unknown");

	// The table never holds more than its depth
	property p_table_bound;
		@(posedge clk) disable iff (!arst_n)
		32'(entry_total_q) <= MAX_STATES;
	endproperty
	a_table_bound: assert property (p_table_bound)
		else $error("entry count beyond table depth");

	// A duplicate load leaves the table size alone
	property p_dup_load;
		@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && scan_hit && item_q.cmd == CMD_LOAD) |=> $stable(entry_total_q);
	endproperty
	a_dup_load: assert property (p_dup_load)
		else $error("duplicate load changed the table");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none

module testbench;
	import drts_pkg::*;

	// Command codes the block leaves unused
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;
	localparam int NUM_STATES = 16;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// Predicted statistics state
	logic [31:0] freq_list [NUM_STATES];
	logic [4:0]  freq_count;
	logic [63:0] dwell [NUM_STATES];
	logic [31:0] moves [NUM_STATES][NUM_STATES];
	logic [31:0] move_total;
	logic [63:0] stamp;
	logic [3:0]  cur_idx;
	logic        cur_known;

	result_t     expected_reports [$];
	int          mismatches = 0;
	bit          idle_on = 1'b0;
	int          stall_left = 0;
	logic [63:0] sim_ticks = '0;

	dvfs_residency_transition_stats dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #5 clk = ~clk;

	// Abort a hung run
	initial begin
		#50_000_000;
		$display("tb: failure");
		$finish;
	end

	// Search only the frequencies loaded so far
	function automatic bit find_freq(input logic [31:0] f, output logic [3:0] at);
		at = '0;
		for (int i = 0; i < NUM_STATES; i++) begin
			if (i < freq_count && freq_list[i] == f) begin
				at = 4'(i);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Add the time since the last stamp to the current index
	function automatic void accrue_dwell(input logic [63:0] now);
		if (!cur_known)
			return;
		dwell[cur_idx] += now - stamp;
		stamp = now;
	endfunction

	// Advance the predicted statistics by one item and return its report
	function automatic result_t update_stats(input item_t it);
		result_t     r;
		logic [3:0]  at;
		bit          hit;
		r = '0;
		r.status = STS_DONE;
		case (it.cmd)
			CMD_LOAD: begin
				if (freq_count >= NUM_STATES || find_freq(it.freq, at)) begin
					r.status = STS_DROPPED;
				end else begin
					freq_list[freq_count[3:0]] = it.freq;
					freq_count++;
				end
			end
			CMD_START: begin
				stamp = it.now_time;
				hit = find_freq(it.freq, at);
				cur_idx = hit ? at : 4'd0;
				cur_known = hit;
			end
			CMD_TRANS: begin
				hit = find_freq(it.freq, at);
				if (!cur_known || !hit || at == cur_idx) begin
					r.status = STS_IGNORED;
				end else begin
					accrue_dwell(it.now_time);
					moves[cur_idx][at]++;
					move_total++;
					cur_idx = at;
				end
			end
			CMD_READ_RES: begin
				accrue_dwell(it.now_time);
				if (it.from_index < freq_count)
					r.value = dwell[it.from_index];
				else
					r.status = STS_RANGE;
			end
			CMD_READ_CNT: begin
				if (it.from_index < freq_count && it.to_index < freq_count)
					r.value = {32'd0, moves[it.from_index][it.to_index]};
				else
					r.status = STS_RANGE;
			end
			CMD_CLEAR: begin
				for (int i = 0; i < NUM_STATES; i++) begin
					dwell[i] = '0;
					for (int j = 0; j < NUM_STATES; j++)
						moves[i][j] = '0;
				end
				stamp = it.now_time;
				move_total = '0;
			end
			default: begin
			end
		endcase
		r.total_transitions = move_total;
		r.current_index = cur_idx;
		r.current_valid = cur_known;
		r.entry_count = freq_count;
		return r;
	endfunction

	function automatic item_t pack_item(input logic [2:0] cmd, input logic [31:0] f,
			input logic [63:0] now, input logic [3:0] from, input logic [3:0] to);
		item_t it;
		it.cmd = cmd;
		it.freq = f;
		it.now_time = now;
		it.from_index = from;
		it.to_index = to;
		return it;
	endfunction

	function automatic item_t random_item();
		return pack_item(3'($urandom_range(7)), $urandom, {$urandom, $urandom},
			4'($urandom_range(15)), 4'($urandom_range(15)));
	endfunction

	function automatic logic [31:0] known_freq();
		if (freq_count == 0)
			return $urandom;
		return freq_list[4'($urandom_range(freq_count - 1))];
	endfunction

	// Mostly a loaded index, now and then any index
	function automatic logic [3:0] pick_index();
		if (freq_count == 0 || $urandom_range(7) == 0)
			return 4'($urandom_range(15));
		return 4'($urandom_range(freq_count - 1));
	endfunction

	// Step the timestamp: small steps, sometimes a large jump that may wrap
	function automatic logic [63:0] advance_clock();
		if ($urandom_range(15) == 0)
			sim_ticks += {$urandom, $urandom};
		else
			sim_ticks += $urandom_range(5000);
		return sim_ticks;
	endfunction

	// Offer one item, hold it until the transfer, then record its report
	task automatic send_item(input item_t it);
		if (idle_on && $urandom_range(3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		expected_reports.push_back(update_stats(it));
		@(negedge clk);
	endtask

	// Drive result stall in random bursts
	always @(negedge clk) begin
		if (stall_left == 0 && idle_on && $urandom_range(4) == 0)
			stall_left = $urandom_range(6, 1);
		if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Compare each transferred report with the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected report: value %0h status %0d", result.value, result.status);
				mismatches++;
			end else begin
				want = expected_reports.pop_front();
				if (result.value !== want.value) begin
					$error("value: expected %0h, got %0h", want.value, result.value);
					mismatches++;
				end
				if (result.total_transitions !== want.total_transitions) begin
					$error("total_transitions: expected %0d, got %0d",
						want.total_transitions, result.total_transitions);
					mismatches++;
				end
				if (result.current_index !== want.current_index) begin
					$error("current_index: expected %0d, got %0d",
						want.current_index, result.current_index);
					mismatches++;
				end
				if (result.current_valid !== want.current_valid) begin
					$error("current_valid: expected %0b, got %0b",
						want.current_valid, result.current_valid);
					mismatches++;
				end
				if (result.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d",
						want.entry_count, result.entry_count);
					mismatches++;
				end
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					mismatches++;
				end
			end
		end
	end

	// Empty table, duplicates, wrapping time, same and unknown targets, clear
	task automatic test_directed();
		send_item(pack_item(CMD_READ_RES, 32'd0, 64'd100, 4'd0, 4'd0));
		send_item(pack_item(CMD_READ_CNT, 32'd0, 64'd0, 4'd0, 4'd0));
		send_item(pack_item(CMD_START, 32'd1234, 64'd50, 4'd0, 4'd0));
		send_item(pack_item(CMD_TRANS, 32'd1234, 64'd60, 4'd0, 4'd0));
		send_item(pack_item(CMD_LOAD, 32'd0, 64'd0, 4'd0, 4'd0));
		send_item(pack_item(CMD_LOAD, 32'hFFFF_FFFF, 64'd0, 4'd15, 4'd15));
		send_item(pack_item(CMD_LOAD, 32'd0, 64'd0, 4'd0, 4'd0));
		send_item(pack_item(CMD_LOAD, 32'h5A5A_A5A5, 64'd0, 4'd0, 4'd0));
		send_item(pack_item(CMD_START, 32'd0, 64'hFFFF_FFFF_FFFF_FF00, 4'd0, 4'd0));
		send_item(pack_item(CMD_TRANS, 32'd0, 64'hFFFF_FFFF_FFFF_FF80, 4'd0, 4'd0));
		send_item(pack_item(CMD_TRANS, 32'h0000_1357, 64'hFFFF_FFFF_FFFF_FF90, 4'd0, 4'd0));
		send_item(pack_item(CMD_TRANS, 32'hFFFF_FFFF, 64'h0000_0000_0000_0100, 4'd0, 4'd0));
		send_item(pack_item(CMD_TRANS, 32'h5A5A_A5A5, 64'h8000_0000_0000_0000, 4'd0, 4'd0));
		send_item(pack_item(CMD_TRANS, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 4'd0));
		send_item(pack_item(CMD_READ_RES, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd2, 4'd0));
		send_item(pack_item(CMD_READ_RES, 32'd0, 64'h0000_0000_0001_0000, 4'd3, 4'd0));
		send_item(pack_item(CMD_READ_RES, 32'd0, 64'h0000_0000_0002_0000, 4'd15, 4'd0));
		send_item(pack_item(CMD_READ_CNT, 32'd0, 64'd0, 4'd0, 4'd1));
		send_item(pack_item(CMD_READ_CNT, 32'd0, 64'd0, 4'd2, 4'd0));
		send_item(pack_item(CMD_READ_CNT, 32'd0, 64'd0, 4'd0, 4'd3));
		send_item(pack_item(CMD_READ_CNT, 32'd0, 64'd0, 4'd15, 4'd15));
		send_item(pack_item(CMD_SPARE_6, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 4'd15));
		send_item(pack_item(CMD_SPARE_7, 32'd0, 64'd0, 4'd0, 4'd0));
		send_item(pack_item(CMD_CLEAR, 32'd0, 64'h0123_4567_89AB_CDEF, 4'd0, 4'd0));
		send_item(pack_item(CMD_READ_CNT, 32'd0, 64'd0, 4'd0, 4'd1));
		send_item(pack_item(CMD_START, 32'h0BAD_0000, 64'h0123_4567_89AB_CE00, 4'd0, 4'd0));
		send_item(pack_item(CMD_READ_RES, 32'd0, 64'h0123_4567_89AB_FFFF, 4'd0, 4'd0));
		sim_ticks = 64'h0123_4567_89AC_0000;
	endtask

	// Well-formed sessions with random content, a share of loads and some noise
	task automatic run_traffic(input int n_items, input int load_pct);
		item_t it;
		int    roll;
		for (int k = 0; k < n_items; k++) begin
			roll = $urandom_range(99);
			it = random_item();
			if (!cur_known || $urandom_range(39) == 0) begin
				it.cmd = CMD_START;
				it.freq = known_freq();
			end else if (roll < load_pct) begin
				it.cmd = CMD_LOAD;
				it.freq = $urandom_range(1) ? known_freq() : $urandom;
			end else if (roll < load_pct + 40) begin
				it.cmd = CMD_TRANS;
				it.freq = $urandom_range(9) == 0 ? $urandom : known_freq();
			end else if (roll < load_pct + 60) begin
				it.cmd = CMD_READ_RES;
				it.from_index = pick_index();
			end else if (roll < load_pct + 78) begin
				it.cmd = CMD_READ_CNT;
				it.from_index = pick_index();
				it.to_index = pick_index();
			end else if (roll < load_pct + 80) begin
				it.cmd = CMD_CLEAR;
			end else if (roll < load_pct + 84) begin
				it.cmd = CMD_START;
				it.freq = $urandom_range(3) == 0 ? $urandom : known_freq();
			end
			it.now_time = advance_clock();
			send_item(it);
		end
	endtask

	// Grow the table to its limit, with duplicates along the way
	task automatic test_table_fill();
		while (freq_count < NUM_STATES)
			run_traffic(10, 30);
		run_traffic(20, 30);
	endtask

	task automatic test_sessions();
		run_traffic(1050, 5);
	endtask

	// Fully random items, time included
	task automatic test_noise();
		repeat (150) send_item(random_item());
	endtask

	task automatic test_steady_tail();
		run_traffic(150, 5);
	endtask

	initial begin
		freq_count = '0;
		move_total = '0;
		stamp = '0;
		cur_idx = '0;
		cur_known = 1'b0;
		for (int i = 0; i < NUM_STATES; i++) begin
			freq_list[i] = '0;
			dwell[i] = '0;
			for (int j = 0; j < NUM_STATES; j++)
				moves[i][j] = '0;
		end
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		idle_on = 1'b1;
		test_table_fill();
		test_sessions();
		test_noise();
		idle_on = 1'b0;
		test_steady_tail();
		item_valid <= 1'b0;

		// Drain the remaining reports
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
sv/drts_pkg.sv
sv/drts_alu.sv
sv/dvfs_residency_transition_stats.sv
sim/testbench.sv
